### hdl/pms_pkg.sv
// Shared types for the point median smoother.
// No dependencies; used by pms_out_buffer and point_median_smoother_core.
`default_nettype none

package pms_pkg;

  // Occupancy of the two-entry result buffer.
  typedef struct packed {
    logic main_full;
    logic skid_full;
  } buf_stat_t;

endpackage

`default_nettype wire

### hdl/pms_median_lane.sv
// One median lane: rank-select median over a window of signed coordinates.
// No dependencies; instantiated once per axis by point_median_smoother_core.
`default_nettype none

module pms_median_lane #(
  parameter int WINDOW     = 5,
  parameter int COORD_BITS = 12
) (
  input  logic signed [COORD_BITS-1:0] win_i [WINDOW],
  output logic signed [COORD_BITS-1:0] median_o
);

  localparam int RankW = $clog2(WINDOW);
  localparam logic [RankW-1:0] MidRank = RankW'(WINDOW / 2);

  logic [RankW-1:0] rank [WINDOW];

  // Rank of each entry in ascending order; equal values are ordered by slot.
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WINDOW; j++) begin
        if ((win_i[j] < win_i[i]) || ((j < i) && (win_i[j] == win_i[i]))) begin
          rank[i] = rank[i] + RankW'(1);
        end
      end
    end
  end

  // Exactly one entry holds the middle rank.
  always_comb begin
    median_o = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (rank[i] == MidRank) begin
        median_o = median_o | win_i[i];
      end
    end
  end

endmodule

`default_nettype wire

### hdl/pms_out_buffer.sv
// Merging stage: two-entry output buffer (main register plus skid) for results.
// Depends on pms_pkg for the occupancy struct.
`default_nettype none

module pms_out_buffer #(
  parameter int DATA_W = 25
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  input  logic [DATA_W-1:0] push_data_i,
  input  logic              pop_stall_i,
  output logic [DATA_W-1:0] pop_data_o,
  output pms_pkg::buf_stat_t stat_o
);

  logic              main_valid_q, skid_valid_q;
  logic [DATA_W-1:0] main_q, skid_q;
  logic              push, pop;

  assign push = push_valid_i && !skid_valid_q;
  assign pop  = main_valid_q && !pop_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (main_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end
      main_valid_q <= 1'b1;
    end else if (pop) begin
      main_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        main_q <= skid_q;
      end
    end else if (push) begin
      if (main_valid_q && !pop) begin
        skid_q <= push_data_i;
      end else begin
        main_q <= push_data_i;
      end
    end
  end

  assign pop_data_o       = main_q;
  assign stat_o.main_full = main_valid_q;
  assign stat_o.skid_full = skid_valid_q;

endmodule

`default_nettype wire

### hdl/point_median_smoother_core.sv
// Top level of the point median smoother: history window, two median lanes, result buffer.
// Depends on pms_pkg, pms_median_lane and pms_out_buffer.
`default_nettype none

// Temporal median smoother for one (x, y) point per transfer. The first WINDOW
// points pass straight through with filtered_o low while they fill the history
// window. From then on each transfer returns the per-axis median of the WINDOW
// points received before it (so the output lags by one point) with filtered_o
// high, and the new point replaces the oldest one. Throughput is one point per
// clock while point_stall_o is low: both axis lanes find their median in the
// accept cycle from a rank count over the window registers, and the result is
// registered in the output register, or in the skid entry if one is waiting. A
// two-entry output buffer lets an input transfer complete while one result still
// waits downstream; point_stall_o rises only once two results are queued.
module point_median_smoother_core #(
  parameter int WINDOW     = 5,
  parameter int COORD_BITS = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         point_valid_i,
  output logic                         point_stall_o,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  output logic                         smooth_valid_o,
  input  logic                         smooth_stall_i,
  output logic signed [COORD_BITS-1:0] smooth_x_o,
  output logic signed [COORD_BITS-1:0] smooth_y_o,
  output logic                         filtered_o
);

  localparam int FillW = $clog2(WINDOW + 1);
  localparam logic [FillW-1:0] FullCount = FillW'(WINDOW);
  localparam int ResW = 2 * COORD_BITS + 1;

  logic signed [COORD_BITS-1:0] hist_x_q [WINDOW];
  logic signed [COORD_BITS-1:0] hist_y_q [WINDOW];
  logic [FillW-1:0]             fill_q, fill_d;
  logic                         in_xfer;
  logic                         warm;
  logic signed [COORD_BITS-1:0] med_x, med_y;
  logic [ResW-1:0]              res_d, res_q;
  pms_pkg::buf_stat_t           stat;

  assign in_xfer = point_valid_i && !point_stall_o;
  assign warm    = (fill_q != FullCount);

  // Count points up to the window size, then hold.
  assign fill_d = warm ? (fill_q + FillW'(1)) : fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (in_xfer) begin
      fill_q <= fill_d;
    end
  end

  // Shift the new point in at the top and drop the oldest; during warm-up the
  // window is never read, so filling by shifting gives the same set of points.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      for (int i = 0; i < WINDOW - 1; i++) begin
        hist_x_q[i] <= hist_x_q[i+1];
        hist_y_q[i] <= hist_y_q[i+1];
      end
      hist_x_q[WINDOW-1] <= point_x_i;
      hist_y_q[WINDOW-1] <= point_y_i;
    end
  end

  // One lane per axis.
  pms_median_lane #(
    .WINDOW    (WINDOW),
    .COORD_BITS(COORD_BITS)
  ) u_lane_x (
    .win_i   (hist_x_q),
    .median_o(med_x)
  );

  pms_median_lane #(
    .WINDOW    (WINDOW),
    .COORD_BITS(COORD_BITS)
  ) u_lane_y (
    .win_i   (hist_y_q),
    .median_o(med_y)
  );

  // Merge the lane results, or pass the raw point during warm-up.
  assign res_d = warm ? {point_x_i, point_y_i, 1'b0} : {med_x, med_y, 1'b1};

  pms_out_buffer #(
    .DATA_W(ResW)
  ) u_out_buffer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(point_valid_i),
    .push_data_i (res_d),
    .pop_stall_i (smooth_stall_i),
    .pop_data_o  (res_q),
    .stat_o      (stat)
  );

  assign point_stall_o  = stat.skid_full;
  assign smooth_valid_o = stat.main_full;
  assign smooth_x_o     = res_q[ResW-1 -: COORD_BITS];
  assign smooth_y_o     = res_q[COORD_BITS:1];
  assign filtered_o     = res_q[0];

`ifndef ASSERT_OFF
  // Skid entry is only used behind a waiting main entry.
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.skid_full |-> stat.main_full)
    else $error("skid entry held without a main entry");

  // A transfer always leaves a result ready in the next cycle.
  a_xfer_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> smooth_valid_o)
    else $error("input transfer produced no result");

  // Once the window is full it stays full.
  a_fill_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == FullCount) |=> (fill_q == FullCount))
    else $error("fill count left saturation");

  // A warm-up transfer never produces a median.
  a_warm_passthrough: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && warm && !smooth_valid_o) |=> !filtered_o)
    else $error("median flagged during warm-up");
`endif

endmodule

`default_nettype wire
